### hw/rtl/ppfd_pkg.sv
// Shared types, register map and field layout of the pulse pair frame decoder.
package ppfd_pkg;

    // Fixed field widths
    localparam int DUR_FIELD_W = 16;
    localparam int PCT_W       = 7;
    localparam int FB_W        = 7;
    localparam int FRAME_W     = 64;
    localparam int SERIAL_LSB  = 28;
    localparam int SERIAL_W    = 20;
    localparam int SEEN_W      = 7;
    localparam int STATUS_W    = 2;

    // Stream layout
    localparam int S_DATA_W = 2 * DUR_FIELD_W;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 96;
    localparam int M_USER_W = STATUS_W;
    localparam int M_PAD_W  = M_DATA_W - FRAME_W - SERIAL_W - SEEN_W;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_SHORT_TIME        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LONG_TIME         = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE_TIME    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE_PERCENT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_BITS        = 3'd4;

    // Default parameter values
    localparam int MAX_FRAME_BITS = 64;
    localparam int DURATION_WIDTH = 16;
    localparam int FIFO_DEPTH     = 4;

    localparam int PERCENT_DIV = 100;

    typedef struct packed {
        logic [DUR_FIELD_W-1:0] short_time;
        logic [DUR_FIELD_W-1:0] long_time;
        logic [DUR_FIELD_W-1:0] tolerance_time;
        logic [PCT_W-1:0]       tolerance_percent;
        logic [FB_W-1:0]        frame_bits;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        short_time:        16'd160,
        long_time:         16'd320,
        tolerance_time:    16'd0,
        tolerance_percent: 7'd25,
        frame_bits:        7'd48
    };

    typedef enum logic [1:0] {
        KIND_BIT0 = 2'd0,
        KIND_BIT1 = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  first;
        logic  last;
    } item_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FRAME  = 2'd0,
        ST_PARITY = 2'd1,
        ST_TIMING = 2'd2,
        ST_SHORT  = 2'd3
    } status_t;

endpackage

### hw/rtl/pwm_pulse_pair_frame_decoder.sv
// Top level of the pulse pair frame decoder: register port, front end, queue and back end.
//
// Each input transfer carries one high/low duration pair; a short-high/long-low pair
// decodes as 0, a long-high/short-low pair as 1, each duration matching when it lies
// strictly within the tolerance (tolerance_time, or short_time * tolerance_percent / 100
// when tolerance_time is zero). s_tuser marks the first pair of a capture, s_tlast the
// last. One result transfer comes out for a complete frame (parity checked), a timing
// mismatch or a capture that ends early; m_tuser carries the status. The block takes
// one pair per clock while results are taken and the queue has room: the per-pair bit update
// in the back end is registered, and a two-stage front end plus a four-entry queue sit ahead
// of it. The derived tolerance follows a register write through prod_reg and then tol_reg.
module pwm_pulse_pair_frame_decoder #(
    parameter int MAX_FRAME_BITS = ppfd_pkg::MAX_FRAME_BITS,
    parameter int DURATION_WIDTH = ppfd_pkg::DURATION_WIDTH,
    parameter int FIFO_DEPTH     = ppfd_pkg::FIFO_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: high_time, low_time
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ppfd_pkg::S_DATA_W-1:0]    s_tdata,
    // s_tuser: first_pair
    input  logic [ppfd_pkg::S_USER_W-1:0]    s_tuser,
    input  logic                             s_tlast,
    // m_tdata: frame_data, serial_number, bits_seen, zero pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ppfd_pkg::M_DATA_W-1:0]    m_tdata,
    // m_tuser: status
    output logic [ppfd_pkg::M_USER_W-1:0]    m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppfd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ppfd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ppfd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    ppfd_pkg::cfg_t                      cfg;
    logic                                q_in_valid;
    logic                                q_in_ready;
    ppfd_pkg::item_t                     q_in_item;
    logic                                q_out_valid;
    logic                                q_out_ready;
    logic [$bits(ppfd_pkg::item_t)-1:0]  q_out_data;
    ppfd_pkg::item_t                     q_out_item;
    ppfd_pkg::status_t                   status;
    logic [ppfd_pkg::FRAME_W-1:0]        frame_data;
    logic [ppfd_pkg::SEEN_W-1:0]         bits_seen;

    ppfd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppfd_front #(
        .DURATION_WIDTH (DURATION_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_item   (q_in_item)
    );

    ppfd_fifo #(
        .WIDTH ($bits(ppfd_pkg::item_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    assign q_out_item = ppfd_pkg::item_t'(q_out_data);

    ppfd_back #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_bits (cfg.frame_bits),
        .q_valid    (q_out_valid),
        .q_ready    (q_out_ready),
        .q_item     (q_out_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .status     (status),
        .frame_data (frame_data),
        .bits_seen  (bits_seen)
    );

    assign m_tuser = status;
    assign m_tdata = {{ppfd_pkg::M_PAD_W{1'b0}}, bits_seen,
                      frame_data[ppfd_pkg::SERIAL_LSB +: ppfd_pkg::SERIAL_W], frame_data};

    // Input stalls only because the queue is full and the front end holds a pair
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (q_in_valid && !q_in_ready))
        else $error("input stalled without a full queue");

    // No pop while a result is still waiting to be taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !q_out_ready)
        else $error("back end ready while result stalled");

    a_seen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (bits_seen <= ppfd_pkg::SEEN_W'(MAX_FRAME_BITS)))
        else $error("bit count beyond frame limit");

    // Every result other than a timing mismatch has decoded at least one bit
    a_seen_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status != ppfd_pkg::ST_TIMING)) |-> (bits_seen != '0))
        else $error("result with no decoded bits");

endmodule

### hw/rtl/ppfd_regs.sv
// Configuration register file behind the APB-style port.
module ppfd_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppfd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ppfd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ppfd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output ppfd_pkg::cfg_t                   cfg
);

    ppfd_pkg::cfg_t                       cfg_reg;
    logic [ppfd_pkg::REG_IDX_W-1:0]       reg_idx;
    logic                                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ppfd_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= ppfd_pkg::CFG_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                ppfd_pkg::REG_SHORT_TIME: begin
                    cfg_reg.short_time <= pwdata[ppfd_pkg::DUR_FIELD_W-1:0];
                end
                ppfd_pkg::REG_LONG_TIME: begin
                    cfg_reg.long_time <= pwdata[ppfd_pkg::DUR_FIELD_W-1:0];
                end
                ppfd_pkg::REG_TOLERANCE_TIME: begin
                    cfg_reg.tolerance_time <= pwdata[ppfd_pkg::DUR_FIELD_W-1:0];
                end
                ppfd_pkg::REG_TOLERANCE_PERCENT: begin
                    cfg_reg.tolerance_percent <= pwdata[ppfd_pkg::PCT_W-1:0];
                end
                ppfd_pkg::REG_FRAME_BITS: begin
                    cfg_reg.frame_bits <= pwdata[ppfd_pkg::FB_W-1:0];
                end
                default: begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ppfd_pkg::REG_SHORT_TIME:
                prdata = ppfd_pkg::APB_DATA_W'(cfg_reg.short_time);
            ppfd_pkg::REG_LONG_TIME:
                prdata = ppfd_pkg::APB_DATA_W'(cfg_reg.long_time);
            ppfd_pkg::REG_TOLERANCE_TIME:
                prdata = ppfd_pkg::APB_DATA_W'(cfg_reg.tolerance_time);
            ppfd_pkg::REG_TOLERANCE_PERCENT:
                prdata = ppfd_pkg::APB_DATA_W'(cfg_reg.tolerance_percent);
            ppfd_pkg::REG_FRAME_BITS:
                prdata = ppfd_pkg::APB_DATA_W'(cfg_reg.frame_bits);
            default:
                prdata = '0;
        endcase
    end

endmodule

### hw/rtl/ppfd_front.sv
// Front end: accepts pulse pairs, derives the tolerance and classifies each pair.
module ppfd_front #(
    parameter int DURATION_WIDTH = ppfd_pkg::DURATION_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ppfd_pkg::cfg_t                  cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ppfd_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [ppfd_pkg::S_USER_W-1:0]   s_tuser,
    input  logic                            s_tlast,
    output logic                            q_valid,
    input  logic                            q_ready,
    output ppfd_pkg::item_t                 q_item
);

    localparam int DUR_W = (DURATION_WIDTH < ppfd_pkg::DUR_FIELD_W) ?
                           DURATION_WIDTH : ppfd_pkg::DUR_FIELD_W;
    localparam int TOL_W  = DUR_W + 1;
    localparam int PROD_W = DUR_W + ppfd_pkg::PCT_W;
    localparam int RECIP_SHIFT = PROD_W + $clog2(ppfd_pkg::PERCENT_DIV);
    localparam int RECIP_W = PROD_W + 1;
    localparam int FULL_W  = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT)
        + 64'(ppfd_pkg::PERCENT_DIV) - 64'd1) / 64'(ppfd_pkg::PERCENT_DIV));

    typedef struct packed {
        logic [DUR_W-1:0] hi;
        logic [DUR_W-1:0] lo;
        logic             first;
        logic             last;
    } pair_t;

    pair_t              in_pair;
    pair_t              st1_reg;
    pair_t              st2_reg;
    logic               st1_valid_reg;
    logic               st2_valid_reg;
    logic               adv;

    logic [DUR_W-1:0]   ts;
    logic [DUR_W-1:0]   tl;
    logic [DUR_W-1:0]   tt;
    logic [PROD_W-1:0]  prod_reg;
    logic [FULL_W-1:0]  quot_full;
    logic [TOL_W-1:0]   tol_reg;

    logic [DUR_W-1:0]   d_hs;
    logic [DUR_W-1:0]   d_ll;
    logic [DUR_W-1:0]   d_hl;
    logic [DUR_W-1:0]   d_ls;
    logic               match0;
    logic               match1;

    assign in_pair.hi    = s_tdata[DUR_W-1:0];
    assign in_pair.lo    = s_tdata[ppfd_pkg::DUR_FIELD_W +: DUR_W];
    assign in_pair.first = s_tuser[0];
    assign in_pair.last  = s_tlast;

    // The whole front advances as one; stage 2 drains into the queue.
    assign adv      = !st2_valid_reg || q_ready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else if (adv) begin
            st1_valid_reg <= s_tvalid;
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_reg <= in_pair;
            st2_reg <= st1_reg;
        end
    end

    // Tolerance runs off the registers, through prod_reg and then tol_reg after a write.
    assign ts = cfg.short_time[DUR_W-1:0];
    assign tl = cfg.long_time[DUR_W-1:0];
    assign tt = cfg.tolerance_time[DUR_W-1:0];

    // Divide by 100 through a reciprocal multiply, exact for this width
    assign quot_full = FULL_W'(prod_reg) * FULL_W'(RECIP);

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(ts) * PROD_W'(cfg.tolerance_percent);
        tol_reg  <= (tt != '0) ? TOL_W'(tt) : quot_full[RECIP_SHIFT +: TOL_W];
    end

    assign d_hs = (st2_reg.hi > ts) ? st2_reg.hi - ts : ts - st2_reg.hi;
    assign d_ll = (st2_reg.lo > tl) ? st2_reg.lo - tl : tl - st2_reg.lo;
    assign d_hl = (st2_reg.hi > tl) ? st2_reg.hi - tl : tl - st2_reg.hi;
    assign d_ls = (st2_reg.lo > ts) ? st2_reg.lo - ts : ts - st2_reg.lo;

    assign match0 = (TOL_W'(d_hs) < tol_reg) && (TOL_W'(d_ll) < tol_reg);
    assign match1 = (TOL_W'(d_hl) < tol_reg) && (TOL_W'(d_ls) < tol_reg);

    // Zero wins when both patterns match
    always_comb begin
        if (match0) begin
            q_item.kind = ppfd_pkg::KIND_BIT0;
        end else if (match1) begin
            q_item.kind = ppfd_pkg::KIND_BIT1;
        end else begin
            q_item.kind = ppfd_pkg::KIND_BAD;
        end
        q_item.first = st2_reg.first;
        q_item.last  = st2_reg.last;
    end

    assign q_valid = st2_valid_reg;

endmodule

### hw/rtl/ppfd_fifo.sv
// Short register queue between the front end and the frame assembler.
module ppfd_fifo #(
    parameter int WIDTH = 4,
    parameter int DEPTH = ppfd_pkg::FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### hw/rtl/ppfd_back.sv
// Back end: shifts decoded bits into the frame, checks parity and holds the result.
module ppfd_back #(
    parameter int MAX_FRAME_BITS = ppfd_pkg::MAX_FRAME_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [ppfd_pkg::FB_W-1:0]       frame_bits,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  ppfd_pkg::item_t                 q_item,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output ppfd_pkg::status_t               status,
    output logic [ppfd_pkg::FRAME_W-1:0]    frame_data,
    output logic [ppfd_pkg::SEEN_W-1:0]     bits_seen
);

    localparam int CNT_W = $clog2(MAX_FRAME_BITS + 1);

    logic [CNT_W-1:0]          len_next;
    logic [CNT_W-1:0]          len_reg;
    logic [MAX_FRAME_BITS-1:0] mask_next;
    logic [MAX_FRAME_BITS-1:0] mask_reg;

    logic [MAX_FRAME_BITS-1:0] shift_reg;
    logic [MAX_FRAME_BITS-1:0] shift_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic                      done_reg;
    logic                      done_next;

    logic                      pop;
    logic                      bit_in;
    logic [MAX_FRAME_BITS-1:0] eff_shift;
    logic [CNT_W-1:0]          eff_cnt;
    logic                      eff_done;
    logic [MAX_FRAME_BITS-1:0] new_shift;
    logic [CNT_W-1:0]          new_cnt;
    logic                      parity;

    logic                      emit;
    ppfd_pkg::status_t         emit_status;
    logic [MAX_FRAME_BITS-1:0] emit_shift;
    logic [CNT_W-1:0]          emit_cnt;

    logic                      out_valid_reg;
    ppfd_pkg::status_t         status_reg;
    logic [MAX_FRAME_BITS-1:0] frame_reg;
    logic [CNT_W-1:0]          seen_reg;

    // Frame length and parity mask are registered from the frame_bits register
    always_comb begin
        if (frame_bits == '0) begin
            len_next = CNT_W'(1);
        end else if (frame_bits > ppfd_pkg::FB_W'(MAX_FRAME_BITS)) begin
            len_next = CNT_W'(MAX_FRAME_BITS);
        end else begin
            len_next = CNT_W'(frame_bits);
        end
        for (int i = 0; i < MAX_FRAME_BITS; i++) begin
            mask_next[i] = (i != 0) && (CNT_W'(i) < len_next);
        end
    end

    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        mask_reg <= mask_next;
    end

    assign q_ready = !out_valid_reg || m_tready;
    assign pop     = q_valid && q_ready;
    assign bit_in  = (q_item.kind == ppfd_pkg::KIND_BIT1);

    // A first pair clears the capture before it is decoded
    assign eff_shift = q_item.first ? '0 : shift_reg;
    assign eff_cnt   = q_item.first ? '0 : cnt_reg;
    assign eff_done  = q_item.first ? 1'b0 : done_reg;

    assign new_shift = {eff_shift[MAX_FRAME_BITS-2:0], bit_in};
    assign new_cnt   = eff_cnt + 1'b1;
    assign parity    = ^(new_shift & mask_reg);

    always_comb begin
        shift_next  = eff_shift;
        cnt_next    = eff_cnt;
        done_next   = eff_done;
        emit        = 1'b0;
        emit_status = ppfd_pkg::ST_TIMING;
        emit_shift  = eff_shift;
        emit_cnt    = eff_cnt;
        if (!eff_done) begin
            case (q_item.kind)
                ppfd_pkg::KIND_BIT0, ppfd_pkg::KIND_BIT1: begin
                    shift_next = new_shift;
                    cnt_next   = new_cnt;
                    emit_shift = new_shift;
                    emit_cnt   = new_cnt;
                    if (new_cnt >= len_reg) begin
                        emit        = 1'b1;
                        done_next   = 1'b1;
                        emit_status = (parity == bit_in) ? ppfd_pkg::ST_FRAME :
                                                           ppfd_pkg::ST_PARITY;
                    end else if (q_item.last) begin
                        emit        = 1'b1;
                        done_next   = 1'b1;
                        emit_status = ppfd_pkg::ST_SHORT;
                    end
                end
                default: begin
                    emit        = 1'b1;
                    done_next   = 1'b1;
                    emit_status = ppfd_pkg::ST_TIMING;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b1;
        end else if (pop) begin
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            status_reg <= emit_status;
            frame_reg  <= emit_shift;
            seen_reg   <= emit_cnt;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign status     = status_reg;
    assign frame_data = ppfd_pkg::FRAME_W'(frame_reg);
    assign bits_seen  = ppfd_pkg::SEEN_W'(seen_reg);

endmodule
